// ===== hdl/mpo_pkg.sv =====
package mpo_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;
	localparam int TAB_DEPTH       = 1 << TABLE_ADDR_BITS;
	localparam int STEP_W          = 40;
	localparam int SUM_W           = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] CMD_PLAIN = 2'd0;
	localparam logic [1:0] CMD_FM    = 2'd1;
	localparam logic [1:0] CMD_PITCH = 2'd2;
	localparam logic [1:0] CMD_SYNC  = 2'd3;

	localparam logic [1:0] REG_INC   = 2'd0;
	localparam logic [1:0] REG_MORPH = 2'd1;
	localparam logic [1:0] REG_DEPTH = 2'd2;

	localparam logic [15:0] MORPH_A = 16'd21627;
	localparam logic [15:0] MORPH_B = 16'd43254;
	localparam logic [31:0] BLEND_M_AB = 32'(((64'd1 << 46) + 64'd21626) / 64'd21627);
	localparam logic [31:0] BLEND_M_C  = 32'(((64'd1 << 46) + 64'd22281) / 64'd22282);
	localparam logic [21:0] DIV6_M     = 22'd2796203;
	localparam logic [17:0] FINE_K     = 18'd242272;
	localparam logic [31:0] ONE30_32   = 32'd1073741824;

	localparam longint     ONE30  = 64'sd1073741824;
	localparam logic [63:0] ONE30U = 64'd1073741824;
	localparam logic [63:0] AMASK  = (64'd1 << TABLE_ADDR_BITS) - 64'd1;

	localparam logic [63:0] SIN_COEF [6] = '{64'd1686629713, 64'd693598668, 64'd85569306,
		64'd5026995, 64'd172272, 64'd3864};
	localparam logic [63:0] HARM_K [7] = '{64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd11};
	localparam longint HARM_W [7] = '{64'sd751619277, 64'sd644245094, 64'sd536870912,
		64'sd483183821, 64'sd375809638, 64'sd268435456, 64'sd214748365};
	localparam logic [63:0] EXP_NEG [8] = '{64'd1073741824, 64'd395007542, 64'd145315154,
		64'd53458458, 64'd19666268, 64'd7234816, 64'd2661540, 64'd979128};
	localparam logic [30:0] SEMI_TAB [16] = '{31'd1073741824, 31'd1137589836, 31'd1205234447,
		31'd1276901417, 31'd1352829926, 31'd1433273380, 31'd1518500250, 31'd1608794974,
		31'd1704458901, 31'd1805811301, 31'd1913190429, 31'd2026954652,
		31'd0, 31'd0, 31'd0, 31'd0};

	typedef logic signed [31:0] rom_t [TAB_DEPTH];

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] fm;
		logic [7:0]         frac;
		logic [3:0]         oct;
		logic [3:0]         rem;
	} item_t;

	typedef struct packed {
		logic [31:0] inc;
		logic [15:0] morph;
		logic [15:0] depth;
	} cfg_t;

	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint smul30(input longint a, input longint b);
		logic        neg;
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] p;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		p = (ua * ub) >> 30;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint sin_turn(input logic [31:0] t);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] s;
		x = {34'd0, t[29:0]};
		if (t[30]) x = ONE30U - x;
		x2 = (x * x) >> 30;
		r = SIN_COEF[5];
		for (int i = 4; i >= 0; i--) r = SIN_COEF[i] - ((r * x2) >> 30);
		s = (r * x) >> 30;
		if (s > ONE30U) s = ONE30U;
		return t[31] ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint sine_val(input logic [63:0] idx);
		return sin_turn(32'((idx & AMASK) << (32 - TABLE_ADDR_BITS)));
	endfunction

	function automatic longint folded_val(input logic [63:0] idx);
		longint      c;
		longint      s;
		longint      v;
		logic [63:0] mag;
		logic [63:0] w;
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] th;
		c = ONE30 - longint'((idx & AMASK) << (31 - TABLE_ADDR_BITS));
		for (int j = 0; j < 7; j++) c = c + smul30(sine_val(HARM_K[j] * idx), HARM_W[j]);
		s = sin_turn(32'(smul30(c, 64'sd1708913189)));
		mag = (s < 0) ? 64'(-s) : 64'(s);
		w = 64'd6 * mag;
		k = w >> 30;
		if (k > 64'd7) k = 64'd7;
		f = w & 64'h3FFF_FFFF;
		r = ONE30U;
		for (int n = 12; n >= 1; n--) r = ONE30U - udiv((f * r) >> 30, 64'(n));
		e = (EXP_NEG[k[2:0]] * r) >> 30;
		th = udiv((ONE30U - e) << 30, ONE30U + e);
		v = (s < 0) ? -longint'(th) : longint'(th);
		if (v > 64'sd858993459) v = 64'sd858993459 + smul30(v - 64'sd858993459, 64'sd322122547);
		if (v < -64'sd858993459) v = -64'sd858993459 + smul30(v + 64'sd858993459, 64'sd322122547);
		if (v > ONE30) v = ONE30;
		if (v < -ONE30) v = -ONE30;
		return v;
	endfunction

	function automatic rom_t build_sine();
		rom_t t;
		for (int i = 0; i < TAB_DEPTH; i++) t[i] = 32'(sine_val(64'(i)));
		return t;
	endfunction

	function automatic rom_t build_folded();
		rom_t t;
		for (int i = 0; i < TAB_DEPTH; i++) t[i] = 32'(folded_val(64'(i)));
		return t;
	endfunction

	localparam rom_t SINE_TAB = build_sine();
	localparam rom_t FOLD_TAB = build_folded();

endpackage

// ===== hdl/morphing_phase_oscillator_unit.sv =====
// Morphing phase-accumulator oscillator. Each tick transaction returns one sample
// taken at the phase before the advance, plus a flag for a forward wrap; a sync
// transaction clears the phase and returns nothing. After reset the sine and
// folded-wave tables are loaded into RAM (one entry per cycle) before the first
// transaction is executed; input is still queued meanwhile. In the execution
// sequencer a tick is fetched from the queue and then runs through eight
// multiply/table steps, while a sync completes at the fetch; a two-entry queue and
// an output register let the input and output sides stall independently.
module morphing_phase_oscillator_unit import mpo_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic signed [15:0]            fm_sample,
	input  logic signed [14:0]            pitch_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          cycle_done,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);

	cfg_t  cfg_q;
	item_t push_item;
	item_t head;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INC:   cfg_q.inc   <= cfg_data;
				REG_MORPH: cfg_q.morph <= cfg_data[15:0];
				REG_DEPTH: cfg_q.depth <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	mpo_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.fm_sample    (fm_sample),
		.pitch_offset (pitch_offset),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	mpo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	mpo_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.cycle_done (cycle_done)
	);

endmodule

// ===== hdl/mpo_ram.sv =====
module mpo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mpo_front.sv =====
module mpo_front import mpo_pkg::*; (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [15:0] fm_sample,
	input  logic signed [14:0] pitch_offset,
	input  logic               q_full,
	output logic               push,
	output item_t              push_item
);

	logic [14:0] u_off;
	logic [7:0]  nn;
	logic [15:0] nn_scaled;
	logic [3:0]  oct;
	logic [7:0]  oct_x12;

	// pitch offset in offset binary, split into octave and semitone
	assign u_off     = pitch_offset ^ 15'h4000;
	assign nn        = {1'b0, u_off[14:8]} + 8'd8;
	assign nn_scaled = {8'd0, nn} * 16'd171;
	assign oct       = nn_scaled[14:11];
	assign oct_x12   = {4'd0, oct} * 8'd12;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.cmd  = command;
		push_item.fm   = fm_sample;
		push_item.frac = u_off[7:0];
		push_item.oct  = oct;
		push_item.rem  = 4'(nn - oct_x12);
	end

endmodule

// ===== hdl/mpo_queue.sv =====
module mpo_queue import mpo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue pop while empty");

endmodule

// ===== hdl/mpo_back.sv =====
module mpo_back import mpo_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  item_t                         head,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          cycle_done
);

	localparam logic [3:0] ST_FILL = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_S1   = 4'd2;
	localparam logic [3:0] ST_S2   = 4'd3;
	localparam logic [3:0] ST_S3   = 4'd4;
	localparam logic [3:0] ST_S4   = 4'd5;
	localparam logic [3:0] ST_S5   = 4'd6;
	localparam logic [3:0] ST_S6   = 4'd7;
	localparam logic [3:0] ST_S7   = 4'd8;
	localparam logic [3:0] ST_S8   = 4'd9;

	logic [3:0]                 state_q;
	logic [TABLE_ADDR_BITS-1:0] fill_q;
	logic [PHASE_BITS-1:0]      phase_q;
	item_t                      item_q;

	logic signed [31:0] sine_rd;
	logic signed [31:0] fold_rd;

	logic [62:0]        blend_prod_q;
	logic [16:0]        b_q;
	logic signed [31:0] a_q;
	logic signed [31:0] c_q;
	logic signed [49:0] mixa_q;
	logic signed [49:0] mixc_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [32:0] fmprod_q;
	logic [31:0]        mag_q;
	logic               fwd_q;
	logic [25:0]        x_q;
	logic [21:0]        x2_q;
	logic [17:0]        x3_q;
	logic [15:0]        x3d_q;
	logic [31:0]        fine_q;
	logic [31:0]        m_q;
	logic [63:0]        dprod_q;
	logic               out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic               done_q;

	logic [PHASE_BITS+29:0] phase_ext;
	logic [29:0]        f30;
	logic signed [33:0] tri_v;
	logic signed [31:0] tri_w;
	logic signed [31:0] sq_w;
	logic [1:0]         seg;
	logic [30:0]        blend_num;
	logic [31:0]        blend_m;
	logic [16:0]        inv_b;
	logic signed [33:0] fac;
	logic signed [50:0] v_sum;
	logic [50:0]        v_pos;
	logic [50:0]        u_rnd;
	logic [STEP_W-1:0]  step;
	logic [5:0]         pshift;
	logic [SUM_W-1:0]   d_ext;
	logic [SUM_W-1:0]   sum;
	logic               load_out;

	function automatic logic signed [32:0] head_fm_mul(input logic signed [15:0] fm,
		input logic [15:0] depth);
		return 33'(fm * $signed({1'b0, depth}));
	endfunction

	mpo_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_sine_ram (
		.clk   (clk),
		.we    (state_q == ST_FILL),
		.waddr (fill_q),
		.wdata (SINE_TAB[fill_q]),
		.raddr (phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
		.rdata (sine_rd)
	);

	mpo_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_fold_ram (
		.clk   (clk),
		.we    (state_q == ST_FILL),
		.waddr (fill_q),
		.wdata (FOLD_TAB[fill_q]),
		.raddr (phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
		.rdata (fold_rd)
	);

	assign phase_ext = {phase_q, 30'd0};
	assign f30       = phase_ext[PHASE_BITS+29:PHASE_BITS];
	assign tri_v     = f30[29] ? (34'sd3221225472 - $signed({2'b00, f30, 2'b00}))
	                           : ($signed({2'b00, f30, 2'b00}) - 34'sd1073741824);
	assign tri_w     = 32'(tri_v);
	assign sq_w      = f30[29] ? -$signed(ONE30_32) : $signed(ONE30_32);

	always_comb begin
		if (cfg.morph <= MORPH_A) begin
			seg       = 2'd0;
			blend_num = 31'({cfg.morph, 16'd0});
			blend_m   = BLEND_M_AB;
		end else if (cfg.morph <= MORPH_B) begin
			seg       = 2'd1;
			blend_num = 31'({16'(cfg.morph - MORPH_A), 16'd0});
			blend_m   = BLEND_M_AB;
		end else begin
			seg       = 2'd2;
			blend_num = 31'({16'(cfg.morph - MORPH_B), 16'd0});
			blend_m   = BLEND_M_C;
		end
	end

	assign inv_b = 17'h10000 - b_q;
	assign fac   = 34'(fmprod_q) + 34'sd536870912;

	assign v_sum = 51'(mixa_q) + 51'(mixc_q) + (51'sd1 <<< 46);
	assign v_pos = v_sum[50] ? '0 : v_sum;
	assign u_rnd = (v_pos + (51'd1 << (46 - SAMPLE_BITS))) >> (47 - SAMPLE_BITS);

	assign pshift = 6'd36 - {2'd0, item_q.oct};

	always_comb begin
		case (item_q.cmd)
			CMD_FM:    step = STEP_W'(dprod_q >> 29);
			CMD_PITCH: step = STEP_W'(dprod_q >> pshift);
			default:   step = STEP_W'(cfg.inc);
		endcase
	end

	assign d_ext    = SUM_W'(step);
	assign sum      = SUM_W'(phase_q) + d_ext;
	assign load_out = (state_q == ST_S8) && (!out_valid_q || out_ready);
	assign pop      = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk) begin
		if (pop) item_q <= head;
		case (state_q)
			ST_S1: begin
				blend_prod_q <= {32'd0, blend_num} * {31'd0, blend_m};
				fmprod_q     <= head_fm_mul(item_q.fm, cfg.depth);
				x_q          <= {18'd0, item_q.frac} * {8'd0, FINE_K};
			end
			ST_S2: begin
				b_q   <= blend_prod_q[62:46];
				mag_q <= fac[33] ? 32'(-fac) : 32'(fac);
				fwd_q <= !fac[33];
				x2_q  <= 22'(({26'd0, x_q} * {26'd0, x_q}) >> 30);
				case (seg)
					2'd0:    begin a_q <= sine_rd; c_q <= tri_w; end
					2'd1:    begin a_q <= tri_w;   c_q <= sq_w;  end
					default: begin a_q <= sq_w;    c_q <= fold_rd; end
				endcase
			end
			ST_S3: begin
				mixa_q  <= 50'(a_q * $signed({1'b0, inv_b}));
				x3_q    <= 18'(({26'd0, x2_q} * {22'd0, x_q}) >> 30);
				dprod_q <= {32'd0, cfg.inc} * {32'd0, mag_q};
			end
			ST_S4: begin
				mixc_q <= 50'(c_q * $signed({1'b0, b_q}));
				x3d_q  <= 16'(({22'd0, x3_q} * {18'd0, DIV6_M}) >> 24);
			end
			ST_S5: begin
				smp_q  <= (u_rnd >= (51'd1 << SAMPLE_BITS)) ?
				          {1'b0, {(SAMPLE_BITS-1){1'b1}}} :
				          SAMPLE_BITS'(u_rnd - (51'd1 << (SAMPLE_BITS - 1)));
				fine_q <= ONE30_32 + 32'(x_q) + 32'(x2_q >> 1) + 32'(x3d_q);
			end
			ST_S6: m_q <= 32'(({33'd0, SEMI_TAB[item_q.rem]} * {32'd0, fine_q}) >> 30);
			ST_S7: if (item_q.cmd == CMD_PITCH) dprod_q <= {32'd0, cfg.inc} * {32'd0, m_q};
			default: ;
		endcase
		if (load_out) begin
			sample_q <= smp_q;
			done_q   <= (item_q.cmd != CMD_FM || fwd_q) && (|(sum >> PHASE_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						if (head.cmd == CMD_SYNC) phase_q <= '0;
						else state_q <= ST_S1;
					end
				end
				ST_S8: begin
					if (load_out) begin
						if (item_q.cmd == CMD_FM && !fwd_q)
							phase_q <= phase_q - d_ext[PHASE_BITS-1:0];
						else
							phase_q <= sum[PHASE_BITS-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7: state_q <= state_q + 1'b1;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample     = sample_q;
	assign cycle_done = done_q;

	a_no_pop_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> !pop)
		else $error("transaction taken before tables are loaded");
	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.cmd == CMD_SYNC) |=> (phase_q == '0))
		else $error("sync did not clear phase");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(sample_q) && $stable(done_q)))
		else $error("pending result overwritten");
	a_phase_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_S8) |=> $stable(phase_q))
		else $error("phase moved mid tick");

endmodule
